// File: rtl/csrgb_pkg.sv
package csrgb_pkg;

  localparam int MAX_NODES   = 4096;
  localparam int MAX_ARCS    = 65536;
  localparam int WEIGHT_BITS = 32;

  localparam int NODE_W  = $clog2(MAX_NODES);      // node index
  localparam int NODE1_W = $clog2(MAX_NODES + 1);  // node index incl. terminal row
  localparam int SLOT_W  = $clog2(MAX_ARCS);       // edge slot index
  localparam int CNT_W   = 17;                     // counts and offsets

  localparam logic [2:0] ACT_COUNT = 3'd0;
  localparam logic [2:0] ACT_BUILD = 3'd1;
  localparam logic [2:0] ACT_PLACE = 3'd2;
  localparam logic [2:0] ACT_RNODE = 3'd3;
  localparam logic [2:0] ACT_REDGE = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ENDPOINT = 3'd1;
  localparam logic [2:0] ST_MISMATCH = 3'd2;
  localparam logic [2:0] ST_INDEX    = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  localparam logic CFG_NODE_COUNT    = 1'b0;
  localparam logic CFG_DECLARED_ARCS = 1'b1;

  typedef struct packed {
    logic [2:0]             status;
    logic [CNT_W-1:0]       row_start;
    logic [CNT_W-1:0]       out_degree;
    logic [11:0]            edge_target;
    logic [31:0]            edge_weight;
    logic [CNT_W-1:0]       arc_total;
  } result_t;

endpackage

// File: rtl/csrgb_edge_mem.sv
// edge store: target and weight per slot, one write and one registered read
module csrgb_edge_mem (
  input  logic                                clk,
  input  logic                                we,
  input  logic [csrgb_pkg::SLOT_W-1:0]        waddr,
  input  logic [11:0]                         wtarget,
  input  logic [csrgb_pkg::WEIGHT_BITS-1:0]   wweight,
  input  logic [csrgb_pkg::SLOT_W-1:0]        raddr,
  output logic [11:0]                         rtarget,
  output logic [csrgb_pkg::WEIGHT_BITS-1:0]   rweight
);

  logic [11:0]                       tgt_mem [csrgb_pkg::MAX_ARCS];
  logic [csrgb_pkg::WEIGHT_BITS-1:0] wgt_mem [csrgb_pkg::MAX_ARCS];

  always_ff @(posedge clk) begin
    if (we) begin
      tgt_mem[waddr] <= wtarget;
      wgt_mem[waddr] <= wweight;
    end
    rtarget <= tgt_mem[raddr];
    rweight <= wgt_mem[raddr];
  end

endmodule

// File: rtl/csr_graph_builder.sv
// CSR graph builder. Items: count (read-modify-write of the degree entry),
// build (one node per S_BRD/S_BWR pair of states, through the degree, offset
// and cursor memories), place (cursor and next offset read, cursor write,
// edge write), read node and read edge, each then passing through the output
// register. After reset a clearing pass zeroes the degree memory; no item is
// accepted during it. Configuration writes are taken at any time but are meant
// only while the block is idle.
module csr_graph_builder (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [16:0]  cfg_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  // action[2:0], source_node[15:3], target_node[28:16], arc_weight[60:29],
  // position[76:61], zero fill to 80
  input  logic [79:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[2:0], row_start[19:3], out_degree[36:20], edge_target[48:37],
  // edge_weight[80:49], arc_total[97:81], zero fill to 104
  output logic [103:0] out_tdata
);

  localparam int NW  = csrgb_pkg::NODE_W;
  localparam int N1W = csrgb_pkg::NODE1_W;
  localparam int SW  = csrgb_pkg::SLOT_W;
  localparam int CW  = csrgb_pkg::CNT_W;
  localparam int WB  = csrgb_pkg::WEIGHT_BITS;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CNT   = 4'd2;
  localparam logic [3:0] S_BRD   = 4'd3;
  localparam logic [3:0] S_BWR   = 4'd4;
  localparam logic [3:0] S_PL1   = 4'd5;
  localparam logic [3:0] S_PL2   = 4'd6;
  localparam logic [3:0] S_RN1   = 4'd7;
  localparam logic [3:0] S_RN2   = 4'd8;
  localparam logic [3:0] S_RE    = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  // configuration
  logic [12:0] node_count_r;
  logic [16:0] declared_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= '0;
      declared_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        csrgb_pkg::CFG_NODE_COUNT:    node_count_r <= cfg_data[12:0];
        csrgb_pkg::CFG_DECLARED_ARCS: declared_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [N1W-1:0] n_act;
  assign n_act = (node_count_r > 13'(csrgb_pkg::MAX_NODES)) ?
                 N1W'(csrgb_pkg::MAX_NODES) : N1W'(node_count_r);

  // input fields
  logic [2:0]  f_act;
  logic [12:0] f_src, f_dst;
  logic [31:0] f_wt;
  logic [15:0] f_pos;
  assign f_act = in_tdata[2:0];
  assign f_src = in_tdata[15:3];
  assign f_dst = in_tdata[28:16];
  assign f_wt  = in_tdata[60:29];
  assign f_pos = in_tdata[76:61];

  // control and item registers
  logic [3:0]     state_r, state_nxt;
  logic [NW-1:0]  idx_r;
  logic [11:0]    dst_r;
  logic [WB-1:0]  wt_r;
  logic [N1W-1:0] u_r;
  logic [CW-1:0]  acc_r;
  logic [CW-1:0]  cnt_r;
  logic [CW-1:0]  slot_r;
  logic [CW-1:0]  lo_r;
  logic           out_valid_r;
  csrgb_pkg::result_t res_r;
  csrgb_pkg::result_t res_init;

  // memories
  logic [CW-1:0] deg_mem [csrgb_pkg::MAX_NODES];
  logic [CW-1:0] off_mem [csrgb_pkg::MAX_NODES + 1];
  logic [CW-1:0] cur_mem [csrgb_pkg::MAX_NODES];
  logic [NW-1:0] deg_ra, cur_ra;
  logic [N1W-1:0] off_ra;
  logic [CW-1:0] deg_rd, off_rd, cur_rd;
  logic          deg_we, off_we, cur_we;
  logic [NW-1:0] deg_wa, cur_wa;
  logic [N1W-1:0] off_wa;
  logic [CW-1:0] deg_wd, off_wd, cur_wd;

  always_ff @(posedge clk) begin
    if (deg_we) deg_mem[deg_wa] <= deg_wd;
    deg_rd <= deg_mem[deg_ra];
  end
  always_ff @(posedge clk) begin
    if (off_we) off_mem[off_wa] <= off_wd;
    off_rd <= off_mem[off_ra];
  end
  always_ff @(posedge clk) begin
    if (cur_we) cur_mem[cur_wa] <= cur_wd;
    cur_rd <= cur_mem[cur_ra];
  end

  logic          e_we;
  logic [SW-1:0] e_ra;
  logic [11:0]   e_rt;
  logic [WB-1:0] e_rw;
  csrgb_edge_mem u_edge (
    .clk     (clk),
    .we      (e_we),
    .waddr   (slot_r[SW-1:0]),
    .wtarget (dst_r),
    .wweight (wt_r),
    .raddr   (e_ra),
    .rtarget (e_rt),
    .rweight (e_rw)
  );

  // acceptance
  logic accept;
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  logic src_ok, dst_ok, pos_node_ok, pos_edge_ok;
  assign src_ok = (f_src != '0) && ({1'b0, f_src} <= 14'(n_act));
  assign dst_ok = (f_dst != '0) && ({1'b0, f_dst} <= 14'(n_act));
  assign pos_node_ok = 17'(f_pos) < 17'(n_act);
  assign pos_edge_ok = (17'(f_pos) < cnt_r) && (32'(f_pos) < 32'(csrgb_pkg::MAX_ARCS));

  // result as far as it is known at acceptance
  always_comb begin
    res_init = '0;
    unique case (f_act)
      csrgb_pkg::ACT_COUNT: begin
        if (!(src_ok && dst_ok)) res_init.status = csrgb_pkg::ST_ENDPOINT;
        else if (cnt_r >= CW'(csrgb_pkg::MAX_ARCS)) res_init.status = csrgb_pkg::ST_OVERFLOW;
      end
      csrgb_pkg::ACT_BUILD:
        if (n_act == '0 && declared_r != '0) res_init.status = csrgb_pkg::ST_MISMATCH;
      csrgb_pkg::ACT_PLACE:
        if (!(src_ok && dst_ok)) res_init.status = csrgb_pkg::ST_ENDPOINT;
      csrgb_pkg::ACT_RNODE:
        if (!pos_node_ok) res_init.status = csrgb_pkg::ST_INDEX;
      csrgb_pkg::ACT_REDGE:
        if (!pos_edge_ok) res_init.status = csrgb_pkg::ST_INDEX;
      default: ;
    endcase
  end

  logic [12:0] src_m1, dst_m1;
  assign src_m1 = f_src - 13'd1;
  assign dst_m1 = f_dst - 13'd1;

  logic [CW-1:0] hi_lo_diff;
  assign hi_lo_diff = off_rd - lo_r;

  // read addresses and writes
  always_comb begin
    deg_ra = idx_r;
    off_ra = N1W'(idx_r) + N1W'(1);
    cur_ra = idx_r;
    e_ra   = f_pos[SW-1:0];
    deg_we = 1'b0; deg_wa = idx_r; deg_wd = deg_rd + CW'(1);
    off_we = 1'b0; off_wa = u_r;   off_wd = acc_r;
    cur_we = 1'b0; cur_wa = idx_r; cur_wd = slot_r + CW'(1);
    e_we   = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        deg_we = 1'b1; deg_wa = u_r[NW-1:0]; deg_wd = '0;
      end
      S_IDLE: begin
        deg_ra = src_m1[NW-1:0];
        cur_ra = src_m1[NW-1:0];
        off_ra = (f_act == csrgb_pkg::ACT_RNODE) ? N1W'(f_pos) : N1W'(src_m1) + N1W'(1);
      end
      S_CNT: deg_we = 1'b1;
      S_BRD: begin
        deg_ra = u_r[NW-1:0];
        // first row always starts at slot zero
        if (u_r == '0) begin
          off_we = 1'b1; off_wa = '0; off_wd = '0;
        end
      end
      S_BWR: begin
        deg_ra = u_r[NW-1:0] + NW'(1);
        cur_we = 1'b1; cur_wa = u_r[NW-1:0]; cur_wd = acc_r;
        off_we = 1'b1; off_wa = u_r + N1W'(1); off_wd = acc_r + deg_rd;
      end
      S_PL1: begin
        if (!((cur_rd >= off_rd) || (cur_rd >= CW'(csrgb_pkg::MAX_ARCS)))) begin
          cur_we = 1'b1; cur_wd = cur_rd + CW'(1);
        end
      end
      S_PL2: e_we = 1'b1;
      S_RN1: off_ra = N1W'(idx_r) + N1W'(1);
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (u_r == N1W'(csrgb_pkg::MAX_NODES - 1)) state_nxt = S_IDLE;
      S_IDLE: if (accept) begin
        unique case (f_act)
          csrgb_pkg::ACT_COUNT: state_nxt = (src_ok && dst_ok &&
                                 cnt_r < CW'(csrgb_pkg::MAX_ARCS)) ? S_CNT : S_OUT;
          csrgb_pkg::ACT_BUILD: state_nxt = (n_act == '0) ? S_OUT : S_BRD;
          csrgb_pkg::ACT_PLACE: state_nxt = (src_ok && dst_ok) ? S_PL1 : S_OUT;
          csrgb_pkg::ACT_RNODE: state_nxt = pos_node_ok ? S_RN1 : S_OUT;
          csrgb_pkg::ACT_REDGE: state_nxt = pos_edge_ok ? S_RE : S_OUT;
          default:              state_nxt = S_OUT;
        endcase
      end
      S_CNT: state_nxt = S_OUT;
      S_BRD: state_nxt = S_BWR;
      S_BWR: state_nxt = (u_r + N1W'(1) == n_act) ? S_OUT : S_BRD;
      S_PL1: state_nxt = ((cur_rd >= off_rd) || (cur_rd >= CW'(csrgb_pkg::MAX_ARCS))) ?
                         S_OUT : S_PL2;
      S_PL2: state_nxt = S_OUT;
      S_RN1: state_nxt = S_RN2;
      S_RN2: state_nxt = S_OUT;
      S_RE:  state_nxt = S_OUT;
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      u_r         <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: u_r <= u_r + N1W'(1);
        S_IDLE: if (accept) begin
          u_r <= '0;
          if (f_act == csrgb_pkg::ACT_BUILD && n_act == '0) cnt_r <= '0;
        end
        S_CNT: cnt_r <= cnt_r + CW'(1);
        S_BWR: begin
          u_r <= u_r + N1W'(1);
          if (u_r + N1W'(1) == n_act) cnt_r <= acc_r + deg_rd;
        end
        S_OUT: out_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // item payload and result assembly
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: if (accept) begin
        idx_r <= (f_act == csrgb_pkg::ACT_RNODE) ? f_pos[NW-1:0] : src_m1[NW-1:0];
        dst_r <= dst_m1[11:0];
        wt_r  <= f_wt[WB-1:0];
        acc_r <= '0;
        res_r <= res_init;
      end
      S_BWR: begin
        acc_r <= acc_r + deg_rd;
        if (u_r + N1W'(1) == n_act && acc_r + deg_rd != declared_r)
          res_r.status <= csrgb_pkg::ST_MISMATCH;
      end
      S_PL1: begin
        slot_r <= cur_rd;
        if ((cur_rd >= off_rd) || (cur_rd >= CW'(csrgb_pkg::MAX_ARCS)))
          res_r.status <= csrgb_pkg::ST_OVERFLOW;
      end
      S_RN1: lo_r <= off_rd;
      S_RN2: begin
        res_r.row_start  <= lo_r;
        res_r.out_degree <= (off_rd >= lo_r) ? hi_lo_diff : '0;
      end
      S_RE: begin
        res_r.edge_target <= e_rt;
        res_r.edge_weight <= 32'(e_rw);
      end
      S_OUT: res_r.arc_total <= cnt_r;
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, res_r.arc_total, res_r.edge_weight, res_r.edge_target,
                       res_r.out_degree, res_r.row_start, res_r.status};

endmodule
